FILE: rtl/acs_pkg.sv
`default_nettype none

package acs_pkg;

  localparam int unsigned DeckW     = 3;
  localparam int unsigned MaxDecks  = 2 ** DeckW;
  localparam int unsigned DecksDef  = 8;
  localparam int unsigned LevelW    = 13;
  localparam int unsigned KnobW     = 12;
  localparam int unsigned EqBands   = 3;
  localparam int unsigned Carried   = 4;
  localparam int unsigned Stems     = 4;
  localparam int unsigned StemLim   = (Stems < Carried) ? Stems : Carried;

  localparam logic [LevelW-1:0] UnityGain = LevelW'(4096);
  localparam logic [LevelW-1:0] UncueRst  = LevelW'(2048);

  localparam int unsigned FlagLoaded  = 0;
  localparam int unsigned FlagMain    = 1;
  localparam int unsigned FlagMuted   = 2;
  localparam int unsigned FlagEq      = 3;
  localparam int unsigned FlagCueNow  = 4;

  localparam logic [1:0] OrientLeft  = 2'd0;
  localparam logic [1:0] OrientRight = 2'd2;

  localparam logic RegCueThr   = 1'b0;
  localparam logic RegUncueThr = 1'b1;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2
  } acs_op_e;

  typedef struct packed {
    acs_op_e                    op;
    logic [DeckW-1:0]           deck;
    logic [4:0]                 flags;
    logic [LevelW-1:0]          volume;
    logic [1:0]                 orient;
    logic [LevelW-1:0]          xfade_left;
    logic [LevelW-1:0]          xfade_right;
    logic [EqBands*KnobW-1:0]   eq_gains;
    logic [EqBands-1:0]         eq_kills;
    logic [3:0]                 stem_num;
    logic [Carried*KnobW-1:0]   stem_volumes;
    logic [Carried-1:0]         stem_mutes;
  } acs_item_t;

  // per-deck memory, bit0 up: silence known/value, cue known/value, override
  typedef struct packed {
    logic override;
    logic cue_val;
    logic cue_known;
    logic sil_val;
    logic sil_known;
  } deck_mem_t;

  typedef struct packed {
    logic override_active;
    logic silent_now;
    logic cue_value;
    logic write_cue;
  } acs_result_t;

endpackage

`default_nettype wire

FILE: rtl/acs_level.sv
`default_nettype none

module acs_level (
  input  acs_pkg::acs_item_t          item_i,
  input  logic [acs_pkg::LevelW-1:0]  thr_i,
  output logic                        audible_o
);
  import acs_pkg::*;

  logic [LevelW-1:0]  xg;
  logic [EqBands-1:0] band_on;
  logic [Carried-1:0] stem_on;
  logic               flags_ok;
  logic               eq_ok;
  logic               stem_ok;

  always_comb begin
    if (item_i.orient == OrientLeft) begin
      xg = item_i.xfade_left;
    end else if (item_i.orient == OrientRight) begin
      xg = item_i.xfade_right;
    end else begin
      xg = UnityGain;
    end
  end

  always_comb begin
    for (int b = 0; b < EqBands; b++) begin
      band_on[b] = !item_i.eq_kills[b] &&
                   ({1'b0, item_i.eq_gains[b*KnobW +: KnobW]} > thr_i);
    end
  end

  always_comb begin
    for (int s = 0; s < Carried; s++) begin
      stem_on[s] = (s < StemLim) && (32'(item_i.stem_num) > s) &&
                   !item_i.stem_mutes[s] &&
                   ({1'b0, item_i.stem_volumes[s*KnobW +: KnobW]} > thr_i);
    end
  end

  assign flags_ok = item_i.flags[FlagLoaded] && item_i.flags[FlagMain] &&
                    !item_i.flags[FlagMuted];
  assign eq_ok    = !item_i.flags[FlagEq] || (|band_on);
  assign stem_ok  = (item_i.stem_num == '0) || (|stem_on);

  assign audible_o = flags_ok && (item_i.volume > thr_i) && (xg > thr_i) &&
                     eq_ok && stem_ok;

endmodule

`default_nettype wire

FILE: rtl/acs_deck_mem.sv
`default_nettype none

module acs_deck_mem #(
  parameter int unsigned DECKS = acs_pkg::DecksDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  acs_pkg::acs_item_t          item_i,
  input  logic [acs_pkg::LevelW-1:0]  cue_thr_i,
  input  logic [acs_pkg::LevelW-1:0]  uncue_thr_i,
  output acs_pkg::acs_result_t        res_o
);
  import acs_pkg::*;

  // the deck field reaches only MaxDecks entries
  localparam int unsigned MemDepth = (DECKS < MaxDecks) ? DECKS : MaxDecks;
  localparam int unsigned IdxW     = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  deck_mem_t [MemDepth-1:0] mem_q;

  logic              in_range;
  logic [IdxW-1:0]   idx;
  deck_mem_t         rd;
  deck_mem_t         nxt;
  logic              wr;
  logic              clr;
  logic              cue_now;
  logic              ovr;
  logic              silent;
  logic              changed;
  logic              wr_cue;
  logic              audible;
  logic [LevelW-1:0] thr;

  assign in_range = 32'(item_i.deck) < DECKS;
  assign idx      = item_i.deck[IdxW-1:0];
  assign rd       = in_range ? mem_q[idx] : '0;
  assign cue_now  = item_i.flags[FlagCueNow];
  assign thr      = (rd.sil_known && rd.sil_val) ? uncue_thr_i : cue_thr_i;

  acs_level u_level (
    .item_i    (item_i),
    .thr_i     (thr),
    .audible_o (audible)
  );

  assign ovr     = rd.override || (rd.cue_known && (rd.cue_val != cue_now));
  assign silent  = !audible;
  assign changed = !(rd.sil_known && (rd.sil_val == silent));
  assign wr_cue  = changed && (cue_now != silent);

  always_comb begin
    nxt   = '0;
    wr    = 1'b0;
    clr   = 1'b0;
    res_o = '0;
    unique case (item_i.op)
      OP_CLEAR: begin
        clr = 1'b1;
      end
      OP_LOAD: begin
        wr = in_range;
      end
      OP_POLL: begin
        wr = in_range;
        if (in_range && item_i.flags[FlagLoaded]) begin
          nxt.cue_known = 1'b1;
          if (ovr) begin
            nxt.override        = 1'b1;
            nxt.cue_val         = cue_now;
            nxt.sil_known       = rd.sil_known;
            nxt.sil_val         = rd.sil_val;
            res_o.silent_now      = rd.sil_val;
            res_o.override_active = 1'b1;
          end else begin
            nxt.cue_val         = wr_cue ? silent : cue_now;
            nxt.sil_known       = 1'b1;
            nxt.sil_val         = silent;
            res_o.write_cue     = wr_cue;
            res_o.cue_value     = wr_cue && silent;
            res_o.silent_now    = silent;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= '0;
    end else if (fire_i) begin
      if (clr) begin
        mem_q <= '0;
      end else if (wr) begin
        mem_q[idx] <= nxt;
      end
    end
  end

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.op == OP_CLEAR) |=> mem_q == '0)
    else $error("deck memory not cleared");

  a_cue_follows_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.write_cue |=> mem_q[$past(idx)].cue_val == $past(res_o.cue_value))
    else $error("stored cue differs from written cue");

  a_override_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.override_active |=> mem_q[$past(idx)].override)
    else $error("override not kept");

  a_override_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.override_active |-> !res_o.write_cue)
    else $error("cue written under override");

endmodule

`default_nettype wire

FILE: rtl/auto_cue_headphone_select_top.sv
`default_nettype none

// Automatic headphone-cue selector. Each transfer on s_axis is a poll of one
// deck, a track load on one deck, or a clear of all decks (tuser = operation).
// A poll checks whether the deck is audible against cue_threshold, or against
// uncue_threshold while the deck is last known silent, and m_axis reports
// whether the cue button must be written and to what. A cue change made by
// hand puts that deck under override until a load, clear or unloaded poll.
// Every transfer in gives exactly one transfer out. One item per clock is
// sustained while m_axis accepts; each result passes the input register, then
// the result register. The rate is set by the read-modify-write of the
// per-deck state registers. Threshold writes take effect on the next clock.
module auto_cue_headphone_select_top #(
  parameter int unsigned DECKS = acs_pkg::DecksDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [acs_pkg::LevelW-1:0]  cfg_data_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // deck[2:0] deck_flags[7:3] volume[20:8] orientation[22:21]
  // xfade_left_gain[35:23] xfade_right_gain[48:36] eq_gains[84:49]
  // eq_kills[87:85] stem_num[91:88] stem_volumes[139:92] stem_mutes[143:140]
  input  logic [143:0]                s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]                  s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // write_cue[0] cue_value[1] silent_now[2] override_active[3], rest zero
  output logic [7:0]                  m_axis_tdata_o
);
  import acs_pkg::*;

  logic [LevelW-1:0] cue_thr_q;
  logic [LevelW-1:0] uncue_thr_q;
  acs_item_t         item_d;
  acs_item_t         item_q;
  logic              in_vld_q;
  logic              out_vld_q;
  acs_result_t       res_d;
  acs_result_t       res_q;
  logic              out_free;
  logic              fire;
  logic              accept;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign fire            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cue_thr_q   <= '0;
      uncue_thr_q <= UncueRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegCueThr) begin
        cue_thr_q <= cfg_data_i;
      end else if (cfg_idx_i == RegUncueThr) begin
        uncue_thr_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    item_d              = '0;
    item_d.op           = acs_op_e'(s_axis_tuser_i);
    item_d.deck         = s_axis_tdata_i[2:0];
    item_d.flags        = s_axis_tdata_i[7:3];
    item_d.volume       = s_axis_tdata_i[20:8];
    item_d.orient       = s_axis_tdata_i[22:21];
    item_d.xfade_left   = s_axis_tdata_i[35:23];
    item_d.xfade_right  = s_axis_tdata_i[48:36];
    item_d.eq_gains     = s_axis_tdata_i[84:49];
    item_d.eq_kills     = s_axis_tdata_i[87:85];
    item_d.stem_num     = s_axis_tdata_i[91:88];
    item_d.stem_volumes = s_axis_tdata_i[139:92];
    item_d.stem_mutes   = s_axis_tdata_i[143:140];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  acs_deck_mem #(
    .DECKS (DECKS)
  ) u_deck_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item_q),
    .cue_thr_i   (cue_thr_q),
    .uncue_thr_i (uncue_thr_q),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, res_q};

endmodule

`default_nettype wire

FILE: sim/auto_cue_headphone_select_top_test.sv
module auto_cue_headphone_select_top_test;
  import acs_pkg::*;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam logic [1:0] OrientCentre = 2'd1;
  localparam logic [1:0] OrientThree  = 2'd3;
  localparam logic [4:0] FlLoaded = 5'd1 << FlagLoaded;
  localparam logic [4:0] FlMain   = 5'd1 << FlagMain;
  localparam logic [4:0] FlMuted  = 5'd1 << FlagMuted;
  localparam logic [4:0] FlEq     = 5'd1 << FlagEq;
  localparam logic [4:0] FlCue    = 5'd1 << FlagCueNow;
  localparam logic [4:0] FlLive   = FlLoaded | FlMain;
  localparam logic [11:0] KnobMax = 12'hFFF;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldAt    = 300;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned PhaseLen  = 118;

  // Tracks per-deck cue memory and thresholds, predicts each result.
  class cue_tracker;
    deck_mem_t   deck_mem [DecksDef];
    logic [12:0] cue_th;
    logic [12:0] uncue_th;
    acs_result_t cue_decisions_due [$];
    int unsigned mismatches;

    function new();
      foreach (deck_mem[i]) deck_mem[i] = '0;
      cue_th = '0;
      uncue_th = UncueRst;
      mismatches = 0;
    endfunction

    function bit deck_audible(acs_item_t it, logic [12:0] thr);
      logic [12:0] gain;
      logic [11:0] knob;
      int unsigned n;
      bit any;
      if (!it.flags[FlagLoaded] || !it.flags[FlagMain] || it.flags[FlagMuted]) return 0;
      if (it.volume <= thr) return 0;
      case (it.orient)
        OrientLeft:  gain = it.xfade_left;
        OrientRight: gain = it.xfade_right;
        default:     gain = UnityGain;
      endcase
      if (gain <= thr) return 0;
      if (it.flags[FlagEq]) begin
        any = 0;
        for (int i = 0; i < EqBands; i++) begin
          knob = it.eq_gains[i*KnobW +: KnobW];
          if (!it.eq_kills[i] && knob > thr) any = 1;
        end
        if (!any) return 0;
      end
      n = it.stem_num;
      if (n > 0) begin
        if (n > Stems) n = Stems;
        if (n > Carried) n = Carried;
        any = 0;
        for (int i = 0; i < n; i++) begin
          knob = it.stem_volumes[i*KnobW +: KnobW];
          if (!it.stem_mutes[i] && knob > thr) any = 1;
        end
        if (!any) return 0;
      end
      return 1;
    endfunction

    function void take_item(acs_item_t it);
      deck_mem_t m;
      acs_result_t r;
      bit cue_now;
      bit silent;
      r = '0;
      case (it.op)
        OP_CLEAR: foreach (deck_mem[i]) deck_mem[i] = '0;
        OP_LOAD:  deck_mem[it.deck] = '0;
        OP_POLL: begin
          if (!it.flags[FlagLoaded]) begin
            deck_mem[it.deck] = '0;
          end else begin
            m = deck_mem[it.deck];
            cue_now = it.flags[FlagCueNow];
            if (m.cue_known && m.cue_val != cue_now) m.override = 1;
            m.cue_val = cue_now;
            m.cue_known = 1;
            if (m.override) begin
              r.silent_now = m.sil_val;
              r.override_active = 1;
            end else begin
              silent = !deck_audible(it, (m.sil_known && m.sil_val) ? uncue_th : cue_th);
              if (!(m.sil_known && m.sil_val == silent) && cue_now != silent) begin
                r.write_cue = 1;
                r.cue_value = silent;
                m.cue_val = silent;
              end
              m.sil_val = silent;
              m.sil_known = 1;
              r.silent_now = silent;
            end
            deck_mem[it.deck] = m;
          end
        end
        default: ;
      endcase
      cue_decisions_due = {cue_decisions_due, r};
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [7:0] data);
      acs_result_t want;
      if (cue_decisions_due.size() == 0) begin
        $display("%0t: result with none pending, expected none actual %h", $time, data);
        mismatches++;
        return;
      end
      want = cue_decisions_due.pop_front();
      compare_bit("write_cue", want.write_cue, data[0]);
      compare_bit("cue_value", want.cue_value, data[1]);
      compare_bit("silent_now", want.silent_now, data[2]);
      compare_bit("override_active", want.override_active, data[3]);
      if (data[7:4] !== 4'd0) begin
        $display("%0t: padding expected 0 actual %h", $time, data[7:4]);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic          cfg_idx_i;
  logic [12:0]   cfg_data_i;
  logic          s_axis_tvalid_i;
  logic          s_axis_tready_o;
  logic [143:0]  s_axis_tdata_i;
  logic [1:0]    s_axis_tuser_i;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i;
  logic [7:0]    m_axis_tdata_o;

  cue_tracker  track;
  int unsigned accepted_in;
  int unsigned idle_cycles;
  int unsigned hold_left;
  int unsigned stall_left;
  bit          held;
  bit          calm;

  auto_cue_headphone_select_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [12:0] near_level(input logic [12:0] top);
    logic [12:0] base;
    base = $urandom_range(0, 1) ? track.cue_th : track.uncue_th;
    if (base > top) base = top;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return top;
      2, 3:    return base;
      4, 5:    return (base == top) ? top : base + 13'd1;
      6:       return (base == 0) ? '0 : base - 13'd1;
      default: return 13'($urandom_range(0, top));
    endcase
  endfunction

  function automatic acs_item_t make_item(input logic [1:0] op, input logic [2:0] deck,
                                         input logic [4:0] flags, input logic [12:0] vol,
                                         input logic [1:0] orient, input logic [12:0] xl,
                                         input logic [12:0] xr, input logic [35:0] eq,
                                         input logic [2:0] kills, input logic [3:0] sc,
                                         input logic [47:0] sv, input logic [3:0] sm);
    acs_item_t it;
    it.op = acs_op_e'(op);
    it.deck = deck;
    it.flags = flags;
    it.volume = vol;
    it.orient = orient;
    it.xfade_left = xl;
    it.xfade_right = xr;
    it.eq_gains = eq;
    it.eq_kills = kills;
    it.stem_num = sc;
    it.stem_volumes = sv;
    it.stem_mutes = sm;
    return it;
  endfunction

  function automatic acs_item_t random_item();
    acs_item_t it;
    int unsigned r;
    it = '0;
    r = $urandom_range(0, 99);
    if (r < 85) it.op = OP_POLL;
    else if (r < 94) it.op = OP_LOAD;
    else if (r < 97) it.op = OP_CLEAR;
    else it.op = acs_op_e'(OpUnused);
    it.deck = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
    it.flags[FlagLoaded] = $urandom_range(0, 99) < 95;
    it.flags[FlagMain]   = $urandom_range(0, 99) < 92;
    it.flags[FlagMuted]  = $urandom_range(0, 99) < 8;
    it.flags[FlagEq]     = $urandom_range(0, 1);
    it.flags[FlagCueNow] = track.deck_mem[it.deck].cue_val ^ ($urandom_range(0, 99) < 4);
    it.volume = near_level(UnityGain);
    it.orient = 2'($urandom_range(0, 3));
    it.xfade_left = near_level(UnityGain);
    it.xfade_right = near_level(UnityGain);
    if ($urandom_range(0, 1)) begin
      it.eq_gains = 36'({$urandom(), $urandom()});
    end else begin
      for (int i = 0; i < EqBands; i++)
        it.eq_gains[i*KnobW +: KnobW] = 12'(near_level(13'(KnobMax)));
    end
    it.eq_kills = ($urandom_range(0, 9) < 6) ? 3'd0 : 3'($urandom_range(0, 7));
    r = $urandom_range(0, 9);
    if (r < 4) it.stem_num = 4'd0;
    else if (r < 8) it.stem_num = 4'($urandom_range(1, 4));
    else it.stem_num = 4'($urandom_range(5, 15));
    if ($urandom_range(0, 9) < 3) begin
      it.stem_volumes = 48'({$urandom(), $urandom()});
    end else begin
      for (int i = 0; i < Carried; i++)
        it.stem_volumes[i*KnobW +: KnobW] = 12'(near_level(13'(KnobMax)));
    end
    it.stem_mutes = ($urandom_range(0, 9) < 7) ? 4'd0 : 4'($urandom_range(0, 15));
    return it;
  endfunction

  task automatic send_item(input acs_item_t it);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i = {it.stem_mutes, it.stem_volumes, it.stem_num, it.eq_kills, it.eq_gains,
                      it.xfade_right, it.xfade_left, it.orient, it.volume, it.flags, it.deck};
    s_axis_tuser_i = it.op;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track.take_item(it);
    accepted_in++;
    @(negedge clk_i);
  endtask

  task automatic write_thresholds(input logic [12:0] cue, input logic [12:0] uncue);
    s_axis_tvalid_i = 1'b0;
    while (track.cue_decisions_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = RegCueThr;
    cfg_data_i = cue;
    @(negedge clk_i);
    cfg_idx_i = RegUncueThr;
    cfg_data_i = uncue;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    track.cue_th = cue;
    track.uncue_th = uncue;
  endtask

  // result check and stall watchdog
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) track.check_result(m_axis_tdata_o);
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off to back up the block
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && accepted_in >= HoldAt) begin
        held = 1'b1;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else if (calm) begin
        m_axis_tready_i = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    logic [12:0] cue_set [8];
    logic [12:0] uncue_set [8];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    accepted_in = 0;
    idle_cycles = 0;
    hold_left = 0;
    stall_left = 0;
    held = 1'b0;
    calm = 1'b0;
    track = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset thresholds
    send_item(make_item(OP_POLL, 3'd0, 5'd0, '0, OrientCentre, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd0, FlLive, UnityGain, OrientCentre, '0, '0, '0, '0, '0,
                        '0, '0));
    send_item(make_item(OP_POLL, 3'd1, FlLive | FlMuted, UnityGain, OrientCentre, '0, '0,
                        '0, '0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd1, FlLive | FlMuted | FlCue, UnityGain, OrientCentre,
                        '0, '0, '0, '0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd1, FlLive | FlCue, 13'd2048, OrientCentre, '0, '0, '0,
                        '0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd1, FlLive | FlCue, 13'd2049, OrientCentre, '0, '0, '0,
                        '0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd1, FlLive | FlCue, UnityGain, OrientCentre, '0, '0, '0,
                        '0, '0, '0, '0));
    send_item(make_item(OP_LOAD, 3'd1, '0, '0, OrientCentre, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd2, FlLive, UnityGain, OrientLeft, '0, UnityGain, '0, '0,
                        '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd3, FlLive, 13'd1, OrientRight, '0, UnityGain, '0, '0,
                        '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd4, FlLive, UnityGain, OrientThree, '0, '0, '0, '0, '0,
                        '0, '0));
    send_item(make_item(OP_POLL, 3'd5, FlLive | FlEq, UnityGain, OrientCentre, '0, '0, '1,
                        3'd7, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd6, FlLive | FlEq, UnityGain, OrientCentre, '0, '0, '1,
                        3'd0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd7, FlLive, UnityGain, OrientCentre, '0, '0, '0, '0,
                        4'd15, '1, 4'd15));
    send_item(make_item(OP_POLL, 3'd7, FlLive | FlCue, UnityGain, OrientCentre, '0, '0, '0,
                        '0, 4'd15, '1, 4'd0));
    send_item(make_item(OP_POLL, 3'd0, FlLive, UnityGain, OrientCentre, '0, '0, '0, '0,
                        4'd1, '0, '0));
    send_item(make_item(OpUnused, 3'd0, '1, UnityGain, OrientCentre, '0, '0, '0, '0, '0, '0,
                        '0));
    send_item(make_item(OP_CLEAR, 3'd0, '0, '0, OrientCentre, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd0, '1, '0, OrientCentre, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_item(OP_POLL, 3'd3, FlLive | FlEq | FlCue, UnityGain, OrientRight,
                        UnityGain, UnityGain, '1, 3'd0, 4'd4, '1, 4'd0));

    cue_set = '{13'd0, 13'd4096, 13'd4096, 13'd0, 13'd2048, 13'd0, 13'd0, 13'd0};
    uncue_set = '{13'd4096, 13'd0, 13'd4096, 13'd0, 13'd2048, 13'd0, 13'd0, 13'd0};
    for (int p = 5; p < 8; p++) begin
      cue_set[p] = 13'($urandom_range(0, 4096));
      uncue_set[p] = 13'($urandom_range(0, 4096));
    end
    for (int p = 0; p < 8; p++) begin
      write_thresholds(cue_set[p], uncue_set[p]);
      calm = (p == 2 || p == 5);
      for (int n = 0; n < PhaseLen; n++) send_item(random_item());
    end

    s_axis_tvalid_i = 1'b0;
    calm = 1'b0;
    while (track.cue_decisions_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (track.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
